// ===== rtl/voxel_face_ao_shader_assert.svh =====
// Assertion macros for the voxel face AO shader.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef VOXEL_FACE_AO_SHADER_ASSERT_SVH
`define VOXEL_FACE_AO_SHADER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define VFAO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define VFAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VFAO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define VFAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/vfao_pkg.sv =====
package vfao_pkg;

  // Face directions
  localparam logic [2:0] DIR_NORTH = 3'd0;
  localparam logic [2:0] DIR_SOUTH = 3'd1;
  localparam logic [2:0] DIR_EAST  = 3'd2;
  localparam logic [2:0] DIR_WEST  = 3'd3;
  localparam logic [2:0] DIR_UP    = 3'd4;
  localparam logic [2:0] DIR_DOWN  = 3'd5;

  // Render classes
  localparam logic [1:0] CLASS_SOLID       = 2'd0;
  localparam logic [1:0] CLASS_CUTOUT      = 2'd1;
  localparam logic [1:0] CLASS_TRANSLUCENT = 2'd2;

  localparam int unsigned NumDirs  = 6;
  localparam int unsigned NumVerts = 4;

  // Neighbour bits feeding one vertex
  typedef struct packed {
    logic [4:0] side1;
    logic [4:0] side2;
    logic [4:0] corner;
  } pick_t;

  // [direction][vertex][side1, side2, corner]
  localparam logic [4:0] AoPick [NumDirs][NumVerts][3] = '{
    '{'{5'd15, 5'd7,  5'd6},  '{5'd15, 5'd25, 5'd24},
      '{5'd17, 5'd25, 5'd26}, '{5'd17, 5'd7,  5'd8}},
    '{'{5'd11, 5'd1,  5'd2},  '{5'd11, 5'd19, 5'd20},
      '{5'd9,  5'd19, 5'd18}, '{5'd9,  5'd1,  5'd0}},
    '{'{5'd17, 5'd5,  5'd8},  '{5'd17, 5'd23, 5'd26},
      '{5'd11, 5'd23, 5'd20}, '{5'd11, 5'd5,  5'd2}},
    '{'{5'd9,  5'd3,  5'd0},  '{5'd9,  5'd21, 5'd18},
      '{5'd15, 5'd21, 5'd24}, '{5'd15, 5'd3,  5'd6}},
    '{'{5'd21, 5'd19, 5'd18}, '{5'd23, 5'd19, 5'd20},
      '{5'd23, 5'd25, 5'd26}, '{5'd21, 5'd25, 5'd24}},
    '{'{5'd3,  5'd1,  5'd0},  '{5'd3,  5'd7,  5'd6},
      '{5'd5,  5'd7,  5'd8},  '{5'd5,  5'd1,  5'd2}}
  };

  // floor(shade * 255) per direction
  localparam logic [7:0] ShadeByte [NumDirs] = '{
    8'd191, 8'd204, 8'd178, 8'd153, 8'd255, 8'd127
  };

  // Translucent gray: floor(shade_byte * tenths / 10), [direction][occluder count]
  localparam logic [7:0] GrayTab [NumDirs][4] = '{
    '{8'd191, 8'd133, 8'd95,  8'd38},
    '{8'd204, 8'd142, 8'd102, 8'd40},
    '{8'd178, 8'd124, 8'd89,  8'd35},
    '{8'd153, 8'd107, 8'd76,  8'd30},
    '{8'd255, 8'd178, 8'd127, 8'd51},
    '{8'd127, 8'd88,  8'd63,  8'd25}
  };

  // AO byte floor(255 * tenths / 10) per occluder count
  localparam logic [7:0] AlphaTab [4] = '{8'd255, 8'd178, 8'd127, 8'd51};

  // AO level in tenths per occluder count
  localparam logic [3:0] TenthsTab [4] = '{4'd10, 4'd7, 4'd5, 4'd2};

  localparam logic [7:0] AlphaOpaque = 8'd255;

  // Directions six and seven shade as up
  function automatic logic [2:0] dir_clamp(input logic [2:0] dir);
    logic [2:0] res;
    res = (dir > DIR_DOWN) ? DIR_UP : dir;
    return res;
  endfunction

  function automatic pick_t ao_pick(input logic [2:0] dir, input logic [1:0] vtx);
    pick_t res;
    res.side1  = AoPick[dir][vtx][0];
    res.side2  = AoPick[dir][vtx][1];
    res.corner = AoPick[dir][vtx][2];
    return res;
  endfunction

endpackage

// ===== rtl/vfao_in_if.sv =====
interface vfao_in_if;
  logic        valid;
  logic        ready;
  logic [26:0] neighborhood_occluders;
  logic [2:0]  face_direction;
  logic [1:0]  render_class;
  logic [3:0]  neighbor_sky_light;
  logic [3:0]  neighbor_block_light;

  modport source (
    output valid, neighborhood_occluders, face_direction, render_class,
           neighbor_sky_light, neighbor_block_light,
    input  ready
  );
  modport sink (
    input  valid, neighborhood_occluders, face_direction, render_class,
           neighbor_sky_light, neighbor_block_light,
    output ready
  );
endinterface

// ===== rtl/vfao_out_if.sv =====
interface vfao_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] vertex_gray_0;
  logic [7:0] vertex_gray_1;
  logic [7:0] vertex_gray_2;
  logic [7:0] vertex_gray_3;
  logic [7:0] vertex_alpha_0;
  logic [7:0] vertex_alpha_1;
  logic [7:0] vertex_alpha_2;
  logic [7:0] vertex_alpha_3;
  logic       flip_quad;
  logic [3:0] sky_level;
  logic [3:0] block_level;

  modport source (
    output valid, vertex_gray_0, vertex_gray_1, vertex_gray_2, vertex_gray_3,
           vertex_alpha_0, vertex_alpha_1, vertex_alpha_2, vertex_alpha_3,
           flip_quad, sky_level, block_level,
    input  ready
  );
  modport sink (
    input  valid, vertex_gray_0, vertex_gray_1, vertex_gray_2, vertex_gray_3,
           vertex_alpha_0, vertex_alpha_1, vertex_alpha_2, vertex_alpha_3,
           flip_quad, sky_level, block_level,
    output ready
  );
endinterface

// ===== rtl/vfao_vertex.sv =====
// Occluder count for one vertex: 3 when both sides block, else popcount.
module vfao_vertex (
  input  logic [26:0]           occ_i,
  input  vfao_pkg::pick_t       pick_i,
  output logic [1:0]            count_o
);

  logic side1, side2, corner;

  assign side1  = occ_i[pick_i.side1];
  assign side2  = occ_i[pick_i.side2];
  assign corner = occ_i[pick_i.corner];

  always_comb begin
    if (side1 && side2) begin
      count_o = 2'd3;
    end else begin
      count_o = {1'b0, side1} + {1'b0, side2} + {1'b0, corner};
    end
  end

endmodule

// ===== rtl/vfao_shade.sv =====
// Gray and alpha bytes of one vertex from its occluder count.
module vfao_shade (
  input  logic [2:0] dir_i,
  input  logic       translucent_i,
  input  logic [1:0] count_i,
  output logic [7:0] gray_o,
  output logic [7:0] alpha_o
);

  always_comb begin
    if (translucent_i) begin
      gray_o  = vfao_pkg::GrayTab[dir_i][count_i];
      alpha_o = vfao_pkg::AlphaOpaque;
    end else begin
      gray_o  = vfao_pkg::ShadeByte[dir_i];
      alpha_o = vfao_pkg::AlphaTab[count_i];
    end
  end

endmodule

// ===== rtl/voxel_face_ao_shader.sv =====
// Voxel face AO shader: one face in, one shaded face out.
// Path: input beat -> input register -> result register -> output beat.
// Throughput: one beat per cycle unless stalled; all work is combinational in between.
// Reset: rst_ni clears both stage valid flags asynchronously; payload is not reset.
`include "voxel_face_ao_shader_assert.svh"

module voxel_face_ao_shader (
  input  logic        clk_i,
  input  logic        rst_ni,
  vfao_in_if.sink     in_i,
  vfao_out_if.source  out_o
);

  // --------------------------------------------------------------------------
  // Stage 1: input register. Takes a new beat whenever it is empty or its
  // contents move on to the result register in the same cycle.
  // --------------------------------------------------------------------------
  logic        s1_valid_q, s1_valid_d;
  logic [26:0] s1_occ_q;
  logic [2:0]  s1_dir_q;
  logic [1:0]  s1_class_q;
  logic [3:0]  s1_sky_q;
  logic [3:0]  s1_blk_q;

  logic        s2_ready;
  logic        s1_ready;
  logic        in_fire;

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_fire    = in_i.valid && s1_ready;

  always_comb begin
    if (s1_ready) begin
      s1_valid_d = in_i.valid;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_occ_q   <= in_i.neighborhood_occluders;
      s1_dir_q   <= in_i.face_direction;
      s1_class_q <= in_i.render_class;
      s1_sky_q   <= in_i.neighbor_sky_light;
      s1_blk_q   <= in_i.neighbor_block_light;
    end
  end

  // --------------------------------------------------------------------------
  // Shading logic: per-vertex occluder count, then gray/alpha lookup.
  // --------------------------------------------------------------------------
  logic [2:0] dir_eff;
  logic       translucent;
  logic [1:0] count     [vfao_pkg::NumVerts];
  logic [7:0] gray_d    [vfao_pkg::NumVerts];
  logic [7:0] alpha_d   [vfao_pkg::NumVerts];
  logic [3:0] tenths    [vfao_pkg::NumVerts];

  assign dir_eff     = vfao_pkg::dir_clamp(s1_dir_q);
  // Class three behaves like solid/cutout
  assign translucent = (s1_class_q == vfao_pkg::CLASS_TRANSLUCENT);

  for (genvar v = 0; v < vfao_pkg::NumVerts; v++) begin : g_vert
    vfao_vertex u_vertex (
      .occ_i   (s1_occ_q),
      .pick_i  (vfao_pkg::ao_pick(dir_eff, 2'(v))),
      .count_o (count[v])
    );

    vfao_shade u_shade (
      .dir_i         (dir_eff),
      .translucent_i (translucent),
      .count_i       (count[v]),
      .gray_o        (gray_d[v]),
      .alpha_o       (alpha_d[v])
    );

    assign tenths[v] = vfao_pkg::TenthsTab[count[v]];
  end

  // Flip the quad diagonal when the 1-3 pair is brighter than the 0-2 pair
  logic [4:0] sum13, sum02;
  logic       flip_d;
  assign sum13  = {1'b0, tenths[1]} + {1'b0, tenths[3]};
  assign sum02  = {1'b0, tenths[0]} + {1'b0, tenths[2]};
  assign flip_d = (sum13 > sum02);

  // A face with no light at all still gets sky level one
  logic [3:0] sky_d;
  assign sky_d = ((s1_sky_q == 4'd0) && (s1_blk_q == 4'd0)) ? 4'd1 : s1_sky_q;

  // --------------------------------------------------------------------------
  // Stage 2: result register, drives the output channel directly.
  // --------------------------------------------------------------------------
  logic       s2_valid_q, s2_valid_d;
  logic       s2_load;
  logic [7:0] s2_gray_q  [vfao_pkg::NumVerts];
  logic [7:0] s2_alpha_q [vfao_pkg::NumVerts];
  logic       s2_flip_q;
  logic [3:0] s2_sky_q;
  logic [3:0] s2_blk_q;

  assign s2_ready = !s2_valid_q || out_o.ready;
  assign s2_load  = s1_valid_q && s2_ready;

  always_comb begin
    if (s2_ready) begin
      s2_valid_d = s1_valid_q;
    end else begin
      s2_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_gray_q  <= gray_d;
      s2_alpha_q <= alpha_d;
      s2_flip_q  <= flip_d;
      s2_sky_q   <= sky_d;
      s2_blk_q   <= s1_blk_q;
    end
  end

  assign out_o.valid          = s2_valid_q;
  assign out_o.vertex_gray_0  = s2_gray_q[0];
  assign out_o.vertex_gray_1  = s2_gray_q[1];
  assign out_o.vertex_gray_2  = s2_gray_q[2];
  assign out_o.vertex_gray_3  = s2_gray_q[3];
  assign out_o.vertex_alpha_0 = s2_alpha_q[0];
  assign out_o.vertex_alpha_1 = s2_alpha_q[1];
  assign out_o.vertex_alpha_2 = s2_alpha_q[2];
  assign out_o.vertex_alpha_3 = s2_alpha_q[3];
  assign out_o.flip_quad      = s2_flip_q;
  assign out_o.sky_level      = s2_sky_q;
  assign out_o.block_level    = s2_blk_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A held stage-1 beat must not change while the result register is stalled
  `VFAO_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s2_ready,
    s1_valid_q && $stable(s1_occ_q) && $stable(s1_dir_q), "stage 1 lost a stalled beat")
  // Every accepted beat lands in stage 1
  `VFAO_ASSERT_NEXT(a_s1_fill, clk_i, rst_ni, in_i.valid && in_i.ready,
    s1_valid_q, "accepted beat missing in stage 1")
  // An empty stage 1 never back-pressures the input
  `VFAO_ASSERT_IMPL(a_s1_ready, clk_i, rst_ni, !s1_valid_q,
    in_i.ready, "input stalled with empty stage 1")
  // Outputs with no block light carry a nonzero sky level
  `VFAO_ASSERT_IMPL(a_light_floor, clk_i, rst_ni, out_o.valid && (out_o.block_level == 4'd0),
    out_o.sky_level != 4'd0, "zero light output")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Codes the package leaves unnamed but the port width allows
  localparam logic [2:0] DIR_SPARE_LO = 3'd6;
  localparam logic [2:0] DIR_SPARE_HI = 3'd7;
  localparam logic [1:0] CLASS_SPARE  = 2'd3;

  localparam int unsigned RandomFaces = 1300;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReported = 10;
  localparam longint      TimeoutNs   = 7_000_000;

  // Neighbor bits per [direction][vertex][side1, side2, corner]; codes six and seven
  // reuse the up row.
  localparam logic [4:0] OccSel [8][4][3] = '{
    '{'{5'd15, 5'd7,  5'd6},  '{5'd15, 5'd25, 5'd24},
      '{5'd17, 5'd25, 5'd26}, '{5'd17, 5'd7,  5'd8}},
    '{'{5'd11, 5'd1,  5'd2},  '{5'd11, 5'd19, 5'd20},
      '{5'd9,  5'd19, 5'd18}, '{5'd9,  5'd1,  5'd0}},
    '{'{5'd17, 5'd5,  5'd8},  '{5'd17, 5'd23, 5'd26},
      '{5'd11, 5'd23, 5'd20}, '{5'd11, 5'd5,  5'd2}},
    '{'{5'd9,  5'd3,  5'd0},  '{5'd9,  5'd21, 5'd18},
      '{5'd15, 5'd21, 5'd24}, '{5'd15, 5'd3,  5'd6}},
    '{'{5'd21, 5'd19, 5'd18}, '{5'd23, 5'd19, 5'd20},
      '{5'd23, 5'd25, 5'd26}, '{5'd21, 5'd25, 5'd24}},
    '{'{5'd3,  5'd1,  5'd0},  '{5'd3,  5'd7,  5'd6},
      '{5'd5,  5'd7,  5'd8},  '{5'd5,  5'd1,  5'd2}},
    '{'{5'd21, 5'd19, 5'd18}, '{5'd23, 5'd19, 5'd20},
      '{5'd23, 5'd25, 5'd26}, '{5'd21, 5'd25, 5'd24}},
    '{'{5'd21, 5'd19, 5'd18}, '{5'd23, 5'd19, 5'd20},
      '{5'd23, 5'd25, 5'd26}, '{5'd21, 5'd25, 5'd24}}
  };

  // Directional shade byte, floor(shade * 255)
  localparam int unsigned DirShade [8] = '{191, 204, 178, 153, 255, 127, 255, 255};

  // AO level in tenths, by occluder count
  localparam int unsigned AoTenths [4] = '{10, 7, 5, 2};

  typedef struct packed {
    logic [26:0] occ;
    logic [2:0]  dir;
    logic [1:0]  cls;
    logic [3:0]  sky;
    logic [3:0]  blk;
  } face_t;

  typedef struct packed {
    logic [3:0][7:0] gray;
    logic [3:0][7:0] alpha;
    logic            flip;
    logic [3:0]      sky;
    logic [3:0]      blk;
  } shaded_t;

  logic clk_i;
  logic rst_ni;

  vfao_in_if  face_in ();
  vfao_out_if face_out ();

  voxel_face_ao_shader uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (face_in),
    .out_o  (face_out)
  );

  face_t   faces_to_send [$];
  shaded_t shade_due_q [$];

  int unsigned faces_queued;
  int unsigned faces_sent;
  int unsigned faces_shaded;
  int unsigned mismatches;
  int unsigned backpressure_cycles;
  int unsigned tx_gap, tx_quiet;
  int unsigned rx_gap, rx_quiet;
  logic        hold_rx;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shading of one face: per-vertex occluder count -> AO tenths -> gray/alpha bytes.
  function automatic shaded_t shade_face(face_t f);
    shaded_t     r;
    int unsigned tenths [4];
    int unsigned shade;
    int unsigned cnt;
    logic        s1, s2, cn;
    logic        see_through;
    int          v;
    shade       = DirShade[f.dir];
    see_through = (f.cls == vfao_pkg::CLASS_TRANSLUCENT);
    for (v = 0; v < 4; v++) begin
      s1  = f.occ[OccSel[f.dir][v][0]];
      s2  = f.occ[OccSel[f.dir][v][1]];
      cn  = f.occ[OccSel[f.dir][v][2]];
      // two sides already hide the corner
      cnt = (s1 && s2) ? 3 : (int'(s1) + int'(s2) + int'(cn));
      tenths[v] = AoTenths[cnt];
      if (see_through) begin
        r.gray[v]  = 8'(shade * tenths[v] / 10);
        r.alpha[v] = 8'd255;
      end else begin
        r.gray[v]  = 8'(shade);
        r.alpha[v] = 8'(255 * tenths[v] / 10);
      end
    end
    r.flip = (tenths[1] + tenths[3] > tenths[0] + tenths[2]);
    // total darkness still gets a sky level of one
    r.sky  = (f.sky == 4'd0 && f.blk == 4'd0) ? 4'd1 : f.sky;
    r.blk  = f.blk;
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, rare long ones, plus stretches with none.
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Occupancy mixes: uniform, sparse and dense neighborhoods
  function automatic logic [26:0] random_occ();
    case ($urandom_range(0, 3))
      0:       return 27'($urandom);
      1:       return 27'($urandom & $urandom & $urandom);
      2:       return 27'($urandom | $urandom);
      default: return 27'($urandom & $urandom);
    endcase
  endfunction

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MaxReported)
      $display("ERROR @%0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // Face driver: records each accepted beat as an expected result, then offers
  // the next pending face once the slot is free and the gap has run out.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_in.valid                  <= 1'b0;
      face_in.neighborhood_occluders <= '0;
      face_in.face_direction         <= vfao_pkg::DIR_NORTH;
      face_in.render_class           <= vfao_pkg::CLASS_SOLID;
      face_in.neighbor_sky_light     <= '0;
      face_in.neighbor_block_light   <= '0;
      tx_gap   = 0;
      tx_quiet = 0;
    end else begin
      if (face_in.valid && face_in.ready) begin
        shade_due_q.push_back(shade_face('{occ: face_in.neighborhood_occluders,
                                           dir: face_in.face_direction,
                                           cls: face_in.render_class,
                                           sky: face_in.neighbor_sky_light,
                                           blk: face_in.neighbor_block_light}));
        faces_sent++;
      end
      if (face_in.valid && !face_in.ready) backpressure_cycles++;
      if (!face_in.valid || face_in.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          face_in.valid <= 1'b0;
        end else if (faces_to_send.size() > 0) begin
          face_t f;
          f = faces_to_send.pop_front();
          face_in.neighborhood_occluders <= f.occ;
          face_in.face_direction         <= f.dir;
          face_in.render_class           <= f.cls;
          face_in.neighbor_sky_light     <= f.sky;
          face_in.neighbor_block_light   <= f.blk;
          face_in.valid                  <= 1'b1;
          tx_gap = pick_gap(tx_quiet);
        end else begin
          face_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat against the oldest expectation and
  // paces ready with random stalls; hold_rx forces a long stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_out.ready <= 1'b0;
      rx_gap   = 0;
      rx_quiet = 0;
    end else begin
      if (face_out.valid && face_out.ready) begin
        shaded_t want;
        shaded_t got;
        got.gray  = {face_out.vertex_gray_3, face_out.vertex_gray_2,
                     face_out.vertex_gray_1, face_out.vertex_gray_0};
        got.alpha = {face_out.vertex_alpha_3, face_out.vertex_alpha_2,
                     face_out.vertex_alpha_1, face_out.vertex_alpha_0};
        got.flip  = face_out.flip_quad;
        got.sky   = face_out.sky_level;
        got.blk   = face_out.block_level;
        faces_shaded++;
        if (shade_due_q.size() == 0) begin
          flag_mismatch("results outstanding", 0, 1);
        end else begin
          want = shade_due_q.pop_front();
          for (int v = 0; v < 4; v++) begin
            if (got.gray[v] !== want.gray[v])
              flag_mismatch($sformatf("vertex_gray_%0d", v), want.gray[v], got.gray[v]);
            if (got.alpha[v] !== want.alpha[v])
              flag_mismatch($sformatf("vertex_alpha_%0d", v), want.alpha[v], got.alpha[v]);
          end
          if (got.flip !== want.flip) flag_mismatch("flip_quad", want.flip, got.flip);
          if (got.sky !== want.sky) flag_mismatch("sky_level", want.sky, got.sky);
          if (got.blk !== want.blk) flag_mismatch("block_level", want.blk, got.blk);
        end
        rx_gap = pick_gap(rx_quiet);
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else if ($urandom_range(0, 15) == 0) begin
        // occasional stall even with nothing on the output
        rx_gap = pick_gap(rx_quiet);
      end
      face_out.ready <= !hold_rx && (rx_gap == 0);
    end
  end

  // Long receiver stall mid-run so the pipe fills and the input backs up.
  initial begin
    hold_rx = 1'b0;
    while (faces_sent < 400) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #(TimeoutNs);
    $display("FAILURE");
    $finish;
  end

  initial begin
    face_t f;
    rst_ni              = 1'b0;
    faces_sent          = 0;
    faces_shaded        = 0;
    mismatches          = 0;
    backpressure_cycles = 0;

    // Every direction code, spare ones included, with mixed classes and lights
    for (int d = 0; d < 8; d++) begin
      f.occ = random_occ();
      f.dir = 3'(d);
      f.cls = 2'(d);
      f.sky = 4'(d);
      f.blk = 4'(15 - 2 * d);
      faces_to_send.push_back(f);
    end
    // Fully buried and fully open faces across all classes; open ones in darkness
    for (int c = 0; c < 4; c++) begin
      faces_to_send.push_back('{occ: '1, dir: vfao_pkg::DIR_UP, cls: 2'(c),
                                sky: 4'd15, blk: 4'd0});
      faces_to_send.push_back('{occ: '0, dir: vfao_pkg::DIR_DOWN, cls: 2'(c),
                                sky: 4'd0, blk: 4'd0});
    end
    // Only one light source present
    faces_to_send.push_back('{occ: '0, dir: vfao_pkg::DIR_EAST,
                              cls: vfao_pkg::CLASS_SOLID, sky: 4'd0, blk: 4'd7});
    faces_to_send.push_back('{occ: '0, dir: vfao_pkg::DIR_WEST,
                              cls: vfao_pkg::CLASS_CUTOUT, sky: 4'd9, blk: 4'd0});
    // Corner-only occluders on the up face: v0/v2 darker flips the quad, v1/v3 does not
    faces_to_send.push_back('{occ: 27'((1 << 18) | (1 << 26)), dir: vfao_pkg::DIR_UP,
                              cls: vfao_pkg::CLASS_TRANSLUCENT, sky: 4'd15, blk: 4'd15});
    faces_to_send.push_back('{occ: 27'((1 << 20) | (1 << 24)), dir: vfao_pkg::DIR_UP,
                              cls: vfao_pkg::CLASS_SOLID, sky: 4'd3, blk: 4'd4});
    // Both sides of v0 set: count saturates at three without the corner
    faces_to_send.push_back('{occ: 27'((1 << 21) | (1 << 19)), dir: vfao_pkg::DIR_UP,
                              cls: vfao_pkg::CLASS_TRANSLUCENT, sky: 4'd1, blk: 4'd2});
    faces_to_send.push_back('{occ: 27'((1 << 15) | (1 << 7) | (1 << 24)),
                              dir: vfao_pkg::DIR_NORTH,
                              cls: vfao_pkg::CLASS_CUTOUT, sky: 4'd8, blk: 4'd8});

    // Random faces: mostly legal codes, some spare direction and class codes
    for (int i = 0; i < RandomFaces; i++) begin
      f.occ = random_occ();
      if ($urandom_range(0, 19) == 0) begin
        f.dir = 3'($urandom_range(DIR_SPARE_LO, DIR_SPARE_HI));
      end else begin
        f.dir = 3'($urandom_range(vfao_pkg::DIR_NORTH, vfao_pkg::DIR_DOWN));
      end
      if ($urandom_range(0, 19) == 0) begin
        f.cls = CLASS_SPARE;
      end else begin
        f.cls = 2'($urandom_range(vfao_pkg::CLASS_SOLID, vfao_pkg::CLASS_TRANSLUCENT));
      end
      if ($urandom_range(0, 9) == 0) begin
        f.sky = 4'd0;
        f.blk = 4'd0;
      end else begin
        f.sky = 4'($urandom_range(0, 15));
        f.blk = 4'($urandom_range(0, 15));
      end
      faces_to_send.push_back(f);
    end
    faces_queued = faces_to_send.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (faces_sent < faces_queued || shade_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Shaded %0d of %0d faces: all direction and class codes, dark and lit faces,",
             faces_shaded, faces_queued);
    $display("random stalls on both sides and %0d cycles of input backpressure; %0d mismatches.",
             backpressure_cycles, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vfao_pkg.sv
rtl/vfao_in_if.sv
rtl/vfao_out_if.sv
rtl/vfao_vertex.sv
rtl/vfao_shade.sv
rtl/voxel_face_ao_shader.sv
tb/tb.sv
